/* rtl/sbbl_pkg.sv */
// types, constants and register codes shared by the segment box blockage loss unit
package sbbl_pkg;

	localparam int MAX_OBSTACLES = 256;
	localparam int SLOT_AW = $clog2(MAX_OBSTACLES);
	localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);

	localparam int COORD_W = 24;
	localparam int SLOT_W = 8;
	localparam int WEIGHT_W = 12;
	localparam int SIZE_W = 14;
	localparam int OBS_CNT_W = 9;
	localparam int LOSS_W = 34;

	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_COUNT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AP_SIZE_X = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AP_SIZE_Y = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AP_SIZE_Z = 8'd3;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// geometry at doubled resolution
	localparam int G_W = COORD_W + 2;
	localparam int D_W = G_W + 1;
	localparam int N_W = D_W;
	localparam int MP_W = D_W + N_W + 1;
	localparam int S_W = MP_W + 1;

	localparam int T_FRAC = 30;
	localparam int T_W = T_FRAC + 1;
	localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;

	localparam int SQT_W = 2 * (D_W - 1);
	localparam int SQ_W = SQT_W + 2;
	localparam int LEN_W = SQ_W / 2;

	localparam int P1_W = T_W + LEN_W;
	localparam int DIST_W = P1_W - T_FRAC;
	localparam int P2_W = DIST_W + WEIGHT_W;
	localparam int ACC_W = P2_W;
	localparam logic [LOSS_W-1:0] LOSS_CAP = 34'd10240000000;

	typedef struct packed {
		logic operation;
		logic [SLOT_W-1:0] slot;
		logic signed [COORD_W-1:0] x_a;
		logic signed [COORD_W-1:0] y_a;
		logic signed [COORD_W-1:0] z_a;
		logic signed [COORD_W-1:0] x_b;
		logic signed [COORD_W-1:0] y_b;
		logic signed [COORD_W-1:0] z_b;
		logic [WEIGHT_W-1:0] loss_weight;
	} in_item_t;

	typedef struct packed {
		logic clear_path;
		logic [LOSS_W-1:0] path_loss;
	} out_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_lo;
		logic signed [COORD_W-1:0] x_hi;
		logic signed [COORD_W-1:0] y_lo;
		logic signed [COORD_W-1:0] y_hi;
		logic signed [COORD_W-1:0] z_lo;
		logic signed [COORD_W-1:0] z_hi;
		logic [WEIGHT_W-1:0] weight;
	} box_t;

	localparam int BOX_W = $bits(box_t);

endpackage

/* rtl/sbbl_ram.sv */
// generic single write port ram with registered read
module sbbl_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/sbbl_div.sv */
// serial restoring divider for the crossing parameter, one quotient bit per cycle
module sbbl_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sbbl_pkg::N_W-1:0]    num,
	input  logic [sbbl_pkg::N_W-1:0]    den,
	output logic                        done,
	output logic [sbbl_pkg::T_FRAC-1:0] quot
);

	localparam int CW = $clog2(sbbl_pkg::T_FRAC);

	logic [sbbl_pkg::N_W:0] rem_q;
	logic [sbbl_pkg::N_W-1:0] den_q;
	logic [sbbl_pkg::T_FRAC-1:0] quot_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [sbbl_pkg::N_W:0] r2;
	logic [sbbl_pkg::N_W:0] dx;
	logic ge;
	logic last;

	assign r2 = {rem_q[sbbl_pkg::N_W-1:0], 1'b0};
	assign dx = {1'b0, den_q};
	assign ge = (r2 >= dx);
	assign last = (cnt_q == CW'(sbbl_pkg::T_FRAC - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? (r2 - dx) : r2;
			quot_q <= {quot_q[sbbl_pkg::T_FRAC-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

/* rtl/sbbl_sqrt.sv */
// serial integer square root of the squared segment length, one result bit per cycle
module sbbl_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sbbl_pkg::SQ_W-1:0]  value,
	output logic                       done,
	output logic [sbbl_pkg::LEN_W-1:0] root
);

	logic [sbbl_pkg::SQ_W-1:0] v_q;
	logic [sbbl_pkg::SQ_W-1:0] r_q;
	logic [sbbl_pkg::SQ_W-1:0] bit_q;
	logic [sbbl_pkg::SQ_W-1:0] trial;
	logic busy_q;
	logic done_q;

	assign trial = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && bit_q[0];
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= value;
			r_q <= '0;
			bit_q <= sbbl_pkg::SQ_W'(1) << (sbbl_pkg::SQ_W - 2);
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[sbbl_pkg::LEN_W-1:0];

endmodule

/* rtl/segment_box_blockage_loss_unit.sv */
// top level: obstacle store, query sequencer and loss accumulation
// A load beat writes one box into the obstacle ram. A query beat first forms the segment
// length (serial square root), then walks the first obstacle_count slots (at most 256)
// one at a time through the single ram read port: each box is read and checked, a box that
// is not rejected has its faces examined in turn, each counted crossing goes through the
// serial divider (at most two per box), and a box with two points forms its loss through
// the length product, weight product and accumulation. The result then moves to the output
// register once that is free. The input is ready only between queries; a finished result
// waits in the output register while the next beat is taken.
module segment_box_blockage_loss_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  sbbl_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output sbbl_pkg::out_item_t                 out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sbbl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sbbl_pkg::CFG_DATA_W-1:0]     cfg_data
);

	typedef enum logic [17:0] {
		S_IDLE  = 18'h00001,
		S_SQR   = 18'h00002,
		S_SUM   = 18'h00004,
		S_ROOT  = 18'h00008,
		S_RD    = 18'h00010,
		S_BOX   = 18'h00020,
		S_CHK   = 18'h00040,
		S_FSET  = 18'h00080,
		S_FMUL  = 18'h00100,
		S_FCMP  = 18'h00200,
		S_FDIV  = 18'h00400,
		S_FNEXT = 18'h00800,
		S_BEND  = 18'h01000,
		S_DMUL  = 18'h02000,
		S_WMUL  = 18'h04000,
		S_LACC  = 18'h08000,
		S_NEXT  = 18'h10000,
		S_FIN   = 18'h20000
	} state_t;

	typedef enum logic [2:0] {
		F_XLO = 3'd0,
		F_XHI = 3'd1,
		F_YLO = 3'd2,
		F_YHI = 3'd3,
		F_ZLO = 3'd4,
		F_ZHI = 3'd5
	} face_t;

	localparam int G_W = sbbl_pkg::G_W;
	localparam int D_W = sbbl_pkg::D_W;
	localparam int N_W = sbbl_pkg::N_W;
	localparam int MP_W = sbbl_pkg::MP_W;
	localparam int S_W = sbbl_pkg::S_W;
	localparam int T_W = sbbl_pkg::T_W;
	localparam int CNT_W = sbbl_pkg::CNT_W;

	state_t state_q;
	face_t f_q;

	logic [sbbl_pkg::OBS_CNT_W-1:0] obstacle_count_q;
	logic [sbbl_pkg::SIZE_W-1:0] ap_size_q [3];

	logic signed [G_W-1:0] p_q [3];
	logic signed [G_W-1:0] q_q [3];
	logic signed [G_W-1:0] lo_q [3];
	logic signed [G_W-1:0] hi_q [3];
	logic [sbbl_pkg::WEIGHT_W-1:0] w_q;
	logic [sbbl_pkg::SQT_W-1:0] sqd_q [3];
	logic [sbbl_pkg::LEN_W-1:0] len_q;
	logic [CNT_W-1:0] j_q;
	logic [1:0] hits_q;
	logic [T_W-1:0] t0_q;
	logic [T_W-1:0] t1_q;

	logic [N_W-1:0] num_q;
	logic [N_W-1:0] den_q;
	logic signed [D_W-1:0] dqp1_q, dpl1_q, dph1_q;
	logic signed [D_W-1:0] dqp2_q, dpl2_q, dph2_q;
	logic signed [MP_W-1:0] ma1_q, ml1_q, mh1_q;
	logic signed [MP_W-1:0] ma2_q, ml2_q, mh2_q;

	logic [T_W-1:0] dt_q;
	logic [sbbl_pkg::P1_W-1:0] prod1_q;
	logic [sbbl_pkg::P2_W-1:0] prod2_q;
	logic [sbbl_pkg::LOSS_W-1:0] total_q;

	logic out_valid_q;
	sbbl_pkg::out_item_t out_data_q;

	logic signed [sbbl_pkg::COORD_W-1:0] ca [3];
	logic signed [sbbl_pkg::COORD_W-1:0] cb [3];
	logic in_acc;
	logic ram_we;
	logic ram_re;
	logic [sbbl_pkg::SLOT_AW-1:0] ram_raddr;
	logic [sbbl_pkg::BOX_W-1:0] ram_rdata;
	sbbl_pkg::box_t wr_box;
	sbbl_pkg::box_t rd_box;
	logic [CNT_W-1:0] cnt_eff;

	logic sqrt_start;
	logic sqrt_done;
	logic [sbbl_pkg::LEN_W-1:0] sqrt_root;
	logic div_start;
	logic div_done;
	logic [sbbl_pkg::T_FRAC-1:0] div_quot;

	logic signed [G_W-1:0] pa, qa, plane, p1, q1, lo1, hi1, p2, q2, lo2, hi2;
	logic signed [D_W-1:0] d1, d2;
	logic [N_W-1:0] m1, m2;
	logic crosses;
	logic reject;
	logic q_in_box;
	logic signed [S_W-1:0] sl1, sh1, sl2, sh2;
	logic hit;
	logic [sbbl_pkg::ACC_W-1:0] acc_sum;
	logic out_free;
	logic signed [D_W-1:0] seg_d [3];
	logic [D_W-2:0] seg_mag [3];

	assign ca[0] = in_data.x_a;
	assign ca[1] = in_data.y_a;
	assign ca[2] = in_data.z_a;
	assign cb[0] = in_data.x_b;
	assign cb[1] = in_data.y_b;
	assign cb[2] = in_data.z_b;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || out_ready;

	assign cnt_eff = (int'(obstacle_count_q) > sbbl_pkg::MAX_OBSTACLES)
		? CNT_W'(sbbl_pkg::MAX_OBSTACLES) : CNT_W'(obstacle_count_q);

	// obstacle store
	assign wr_box.x_lo = in_data.x_a;
	assign wr_box.x_hi = in_data.x_b;
	assign wr_box.y_lo = in_data.y_a;
	assign wr_box.y_hi = in_data.y_b;
	assign wr_box.z_lo = in_data.z_a;
	assign wr_box.z_hi = in_data.z_b;
	assign wr_box.weight = in_data.loss_weight;
	assign ram_we = in_acc && (in_data.operation == sbbl_pkg::OP_LOAD)
		&& (int'(in_data.slot) < sbbl_pkg::MAX_OBSTACLES);
	assign ram_re = (state_q == S_RD);
	assign ram_raddr = j_q[sbbl_pkg::SLOT_AW-1:0];
	assign rd_box = sbbl_pkg::box_t'(ram_rdata);

	sbbl_ram #(
		.DATA_W(sbbl_pkg::BOX_W),
		.DEPTH(sbbl_pkg::MAX_OBSTACLES)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(sbbl_pkg::SLOT_AW'(in_data.slot)),
		.wdata(wr_box),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign sqrt_start = (state_q == S_SUM);

	sbbl_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(sqrt_start),
		.value(sbbl_pkg::SQ_W'(sqd_q[0]) + sbbl_pkg::SQ_W'(sqd_q[1])
			+ sbbl_pkg::SQ_W'(sqd_q[2])),
		.done(sqrt_done),
		.root(sqrt_root)
	);

	sbbl_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(num_q),
		.den(den_q),
		.done(div_done),
		.quot(div_quot)
	);

	// segment extent per axis
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			seg_d[k] = D_W'(q_q[k]) - D_W'(p_q[k]);
			seg_mag[k] = seg_d[k][D_W-1] ? (D_W-1)'(-seg_d[k]) : seg_d[k][D_W-2:0];
		end
	end

	// face selection
	always_comb begin
		pa = p_q[0]; qa = q_q[0]; plane = lo_q[0];
		p1 = p_q[1]; q1 = q_q[1]; lo1 = lo_q[1]; hi1 = hi_q[1];
		p2 = p_q[2]; q2 = q_q[2]; lo2 = lo_q[2]; hi2 = hi_q[2];
		case (f_q)
			F_XLO, F_XHI: begin
				pa = p_q[0]; qa = q_q[0];
				plane = (f_q == F_XHI) ? hi_q[0] : lo_q[0];
				p1 = p_q[1]; q1 = q_q[1]; lo1 = lo_q[1]; hi1 = hi_q[1];
				p2 = p_q[2]; q2 = q_q[2]; lo2 = lo_q[2]; hi2 = hi_q[2];
			end
			F_YLO, F_YHI: begin
				pa = p_q[1]; qa = q_q[1];
				plane = (f_q == F_YHI) ? hi_q[1] : lo_q[1];
				p1 = p_q[0]; q1 = q_q[0]; lo1 = lo_q[0]; hi1 = hi_q[0];
				p2 = p_q[2]; q2 = q_q[2]; lo2 = lo_q[2]; hi2 = hi_q[2];
			end
			default: begin
				pa = p_q[2]; qa = q_q[2];
				plane = (f_q == F_ZHI) ? hi_q[2] : lo_q[2];
				p1 = p_q[0]; q1 = q_q[0]; lo1 = lo_q[0]; hi1 = hi_q[0];
				p2 = p_q[1]; q2 = q_q[1]; lo2 = lo_q[1]; hi2 = hi_q[1];
			end
		endcase
	end

	assign d1 = D_W'(pa) - D_W'(plane);
	assign d2 = D_W'(qa) - D_W'(plane);
	assign m1 = d1[D_W-1] ? N_W'(-d1) : N_W'(d1);
	assign m2 = d2[D_W-1] ? N_W'(-d2) : N_W'(d2);
	assign crosses = ((d1 < 0) && (d2 > 0)) || ((d1 > 0) && (d2 < 0));

	always_comb begin
		reject = 1'b0;
		q_in_box = 1'b1;
		for (int k = 0; k < 3; k++) begin
			if ((q_q[k] < lo_q[k]) && (p_q[k] < lo_q[k])) begin
				reject = 1'b1;
			end
			if ((q_q[k] > hi_q[k]) && (p_q[k] > hi_q[k])) begin
				reject = 1'b1;
			end
			if ((q_q[k] < lo_q[k]) || (q_q[k] > hi_q[k])) begin
				q_in_box = 1'b0;
			end
		end
	end

	assign sl1 = S_W'(ma1_q) + S_W'(ml1_q);
	assign sh1 = S_W'(ma1_q) + S_W'(mh1_q);
	assign sl2 = S_W'(ma2_q) + S_W'(ml2_q);
	assign sh2 = S_W'(ma2_q) + S_W'(mh2_q);
	assign hit = (sl1 > 0) && (sh1 < 0) && (sl2 > 0) && (sh2 < 0);
	assign div_start = (state_q == S_FCMP) && hit;

	assign acc_sum = sbbl_pkg::ACC_W'(total_q)
		+ sbbl_pkg::ACC_W'(prod2_q[sbbl_pkg::P2_W-1:1]);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obstacle_count_q <= '0;
			ap_size_q[0] <= '0;
			ap_size_q[1] <= '0;
			ap_size_q[2] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sbbl_pkg::REG_OBSTACLE_COUNT:
					obstacle_count_q <= cfg_data[sbbl_pkg::OBS_CNT_W-1:0];
				sbbl_pkg::REG_AP_SIZE_X: ap_size_q[0] <= cfg_data[sbbl_pkg::SIZE_W-1:0];
				sbbl_pkg::REG_AP_SIZE_Y: ap_size_q[1] <= cfg_data[sbbl_pkg::SIZE_W-1:0];
				sbbl_pkg::REG_AP_SIZE_Z: ap_size_q[2] <= cfg_data[sbbl_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			f_q <= F_XLO;
			j_q <= '0;
			hits_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && (in_data.operation == sbbl_pkg::OP_QUERY)) begin
						state_q <= S_SQR;
					end
				end
				S_SQR: state_q <= S_SUM;
				S_SUM: state_q <= S_ROOT;
				S_ROOT: begin
					if (sqrt_done) begin
						j_q <= '0;
						state_q <= (cnt_eff == '0) ? S_FIN : S_RD;
					end
				end
				S_RD: state_q <= S_BOX;
				S_BOX: state_q <= S_CHK;
				S_CHK: begin
					hits_q <= q_in_box ? 2'd1 : 2'd0;
					f_q <= F_XLO;
					state_q <= reject ? S_NEXT : S_FSET;
				end
				S_FSET: state_q <= crosses ? S_FMUL : S_FNEXT;
				S_FMUL: state_q <= S_FCMP;
				S_FCMP: state_q <= hit ? S_FDIV : S_FNEXT;
				S_FDIV: begin
					if (div_done) begin
						hits_q <= hits_q + 2'd1;
						state_q <= S_FNEXT;
					end
				end
				S_FNEXT: begin
					if ((hits_q == 2'd2) || (f_q == F_ZHI)) begin
						state_q <= S_BEND;
					end else begin
						f_q <= face_t'(f_q + 3'd1);
						state_q <= S_FSET;
					end
				end
				S_BEND: state_q <= (hits_q == 2'd2) ? S_DMUL : S_NEXT;
				S_DMUL: state_q <= S_WMUL;
				S_WMUL: state_q <= S_LACC;
				S_LACC: state_q <= S_NEXT;
				S_NEXT: begin
					if (j_q + CNT_W'(1) == cnt_eff) begin
						state_q <= S_FIN;
					end else begin
						j_q <= j_q + CNT_W'(1);
						state_q <= S_RD;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc && (in_data.operation == sbbl_pkg::OP_QUERY)) begin
			for (int k = 0; k < 3; k++) begin
				p_q[k] <= G_W'($signed({ca[k], 1'b0})) - G_W'(ap_size_q[k]);
				q_q[k] <= G_W'($signed({cb[k], 1'b0}));
			end
			total_q <= '0;
		end
		if (state_q == S_SQR) begin
			for (int k = 0; k < 3; k++) begin
				sqd_q[k] <= seg_mag[k] * seg_mag[k];
			end
		end
		if ((state_q == S_ROOT) && sqrt_done) begin
			len_q <= sqrt_root;
		end
		if (state_q == S_BOX) begin
			lo_q[0] <= G_W'($signed({rd_box.x_lo, 1'b0}));
			hi_q[0] <= G_W'($signed({rd_box.x_hi, 1'b0}));
			lo_q[1] <= G_W'($signed({rd_box.y_lo, 1'b0}));
			hi_q[1] <= G_W'($signed({rd_box.y_hi, 1'b0}));
			lo_q[2] <= G_W'($signed({rd_box.z_lo, 1'b0}));
			hi_q[2] <= G_W'($signed({rd_box.z_hi, 1'b0}));
			w_q <= rd_box.weight;
		end
		if ((state_q == S_CHK) && q_in_box) begin
			t0_q <= sbbl_pkg::T_ONE;
		end
		if (state_q == S_FSET) begin
			num_q <= m1;
			den_q <= m1 + m2;
			dqp1_q <= D_W'(q1) - D_W'(p1);
			dpl1_q <= D_W'(p1) - D_W'(lo1);
			dph1_q <= D_W'(p1) - D_W'(hi1);
			dqp2_q <= D_W'(q2) - D_W'(p2);
			dpl2_q <= D_W'(p2) - D_W'(lo2);
			dph2_q <= D_W'(p2) - D_W'(hi2);
		end
		if (state_q == S_FMUL) begin
			ma1_q <= dqp1_q * $signed({1'b0, num_q});
			ml1_q <= dpl1_q * $signed({1'b0, den_q});
			mh1_q <= dph1_q * $signed({1'b0, den_q});
			ma2_q <= dqp2_q * $signed({1'b0, num_q});
			ml2_q <= dpl2_q * $signed({1'b0, den_q});
			mh2_q <= dph2_q * $signed({1'b0, den_q});
		end
		if ((state_q == S_FDIV) && div_done) begin
			if (hits_q == 2'd0) begin
				t0_q <= {1'b0, div_quot};
			end else begin
				t1_q <= {1'b0, div_quot};
			end
		end
		if (state_q == S_BEND) begin
			dt_q <= (t0_q > t1_q) ? (t0_q - t1_q) : (t1_q - t0_q);
		end
		if (state_q == S_DMUL) begin
			prod1_q <= sbbl_pkg::P1_W'(dt_q) * sbbl_pkg::P1_W'(len_q);
		end
		if (state_q == S_WMUL) begin
			prod2_q <= sbbl_pkg::P2_W'(prod1_q[sbbl_pkg::P1_W-1:sbbl_pkg::T_FRAC])
				* sbbl_pkg::P2_W'(w_q);
		end
		if (state_q == S_LACC) begin
			total_q <= (acc_sum > sbbl_pkg::ACC_W'(sbbl_pkg::LOSS_CAP))
				? sbbl_pkg::LOSS_CAP : acc_sum[sbbl_pkg::LOSS_W-1:0];
		end
		if ((state_q == S_FIN) && out_free) begin
			out_data_q.clear_path <= (total_q == '0);
			out_data_q.path_loss <= total_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

/* tb/sv/sbbl_checker.sv */
// checker for the segment box blockage loss unit: predicts each query's loss and compares
module sbbl_checker
	import sbbl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_item_t              in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_item_t             out_data,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	out_item_t loss_q[$];
	longint box_lo[MAX_OBSTACLES][3];
	longint box_hi[MAX_OBSTACLES][3];
	logic [WEIGHT_W-1:0] box_wt[MAX_OBSTACLES];
	logic [OBS_CNT_W-1:0] obs_count;
	logic [SIZE_W-1:0] ap_size[3];

	initial begin
		mismatches = 0;
		pending = 0;
	end

	function automatic logic [63:0] root_floor(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic bit face_hit(input longint p[3], input longint q[3], input int a,
			input longint plane, input longint lo[3], input longint hi[3], output longint tq);
		longint d1, d2, num, den, lhs;
		tq = 0;
		d1 = p[a] - plane;
		d2 = q[a] - plane;
		if (!((d1 < 0 && d2 > 0) || (d1 > 0 && d2 < 0)))
			return 0;
		num = d1 < 0 ? -d1 : d1;
		den = num + (d2 < 0 ? -d2 : d2);
		for (int k = 0; k < 3; k++) begin
			if (k != a) begin
				lhs = p[k] * den + (q[k] - p[k]) * num;
				if (!(lhs > lo[k] * den && lhs < hi[k] * den))
					return 0;
			end
		end
		tq = (num << 30) / den;
		return 1;
	endfunction

	function automatic out_item_t path_loss_of(in_item_t it);
		longint p[3], q[3], lo[3], hi[3], a[3], b[3];
		longint t0, t1, tq, dt, d;
		logic [63:0] sq, len, span, total;
		int hits, cnt;
		bit reject;
		out_item_t r;
		a[0] = longint'(it.x_a);
		a[1] = longint'(it.y_a);
		a[2] = longint'(it.z_a);
		b[0] = longint'(it.x_b);
		b[1] = longint'(it.y_b);
		b[2] = longint'(it.z_b);
		sq = 0;
		for (int k = 0; k < 3; k++) begin
			p[k] = 2 * a[k] - longint'(ap_size[k]);
			q[k] = 2 * b[k];
			d = q[k] - p[k];
			if (d < 0)
				d = -d;
			sq += d * d;
		end
		len = root_floor(sq);
		cnt = obs_count > MAX_OBSTACLES ? MAX_OBSTACLES : int'(obs_count);
		total = 0;
		for (int j = 0; j < cnt; j++) begin
			reject = 0;
			for (int k = 0; k < 3; k++) begin
				lo[k] = 2 * box_lo[j][k];
				hi[k] = 2 * box_hi[j][k];
				if ((q[k] < lo[k] && p[k] < lo[k]) || (q[k] > hi[k] && p[k] > hi[k]))
					reject = 1;
			end
			if (!reject) begin
				hits = 0;
				t0 = 0;
				t1 = 0;
				if (q[0] >= lo[0] && q[0] <= hi[0] && q[1] >= lo[1] && q[1] <= hi[1] &&
						q[2] >= lo[2] && q[2] <= hi[2]) begin
					t0 = longint'(1) << 30;
					hits = 1;
				end
				for (int k = 0; k < 3; k++) begin
					for (int s = 0; s < 2; s++) begin
						if (face_hit(p, q, k, s ? hi[k] : lo[k], lo, hi, tq)) begin
							if (hits == 0)
								t0 = tq;
							else if (hits == 1)
								t1 = tq;
							hits++;
						end
					end
				end
				if (hits > 1) begin
					dt = t0 > t1 ? t0 - t1 : t1 - t0;
					span = (dt * len) >> 30;
					total += (span * box_wt[j]) >> 1;
					if (total > LOSS_CAP)
						total = LOSS_CAP;
				end
			end
		end
		r.clear_path = total == 0;
		r.path_loss = total[LOSS_W-1:0];
		return r;
	endfunction

	always @(posedge clk) begin
		out_item_t exp_item;
		if (!arst_n) begin
			obs_count = 0;
			ap_size[0] = 0;
			ap_size[1] = 0;
			ap_size[2] = 0;
			loss_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (loss_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: clear=%0d loss=%0d",
							out_data.clear_path, out_data.path_loss);
				end else begin
					exp_item = loss_q.pop_front();
					if (exp_item.clear_path !== out_data.clear_path ||
							exp_item.path_loss !== out_data.path_loss) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"result mismatch: expected clear=%0d loss=%0d,",
								" got clear=%0d loss=%0d"},
								exp_item.clear_path, exp_item.path_loss,
								out_data.clear_path, out_data.path_loss);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_OBSTACLE_COUNT: obs_count = cfg_data[OBS_CNT_W-1:0];
					REG_AP_SIZE_X: ap_size[0] = cfg_data[SIZE_W-1:0];
					REG_AP_SIZE_Y: ap_size[1] = cfg_data[SIZE_W-1:0];
					REG_AP_SIZE_Z: ap_size[2] = cfg_data[SIZE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (in_data.operation == OP_QUERY)
					loss_q = {loss_q, path_loss_of(in_data)};
				else begin
					box_lo[in_data.slot][0] = longint'(in_data.x_a);
					box_lo[in_data.slot][1] = longint'(in_data.y_a);
					box_lo[in_data.slot][2] = longint'(in_data.z_a);
					box_hi[in_data.slot][0] = longint'(in_data.x_b);
					box_hi[in_data.slot][1] = longint'(in_data.y_b);
					box_hi[in_data.slot][2] = longint'(in_data.z_b);
					box_wt[in_data.slot] = in_data.loss_weight;
				end
			end
		end
		pending = loss_q.size();
	end

endmodule

/* tb/sv/segment_box_blockage_loss_unit_test.sv */
// testbench top for the segment box blockage loss unit: stimulus, pacing and verdict
module segment_box_blockage_loss_unit_test;
	import sbbl_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CYCLE_LIMIT = 30000000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int mismatches;
	int pending;
	int burst_left;
	int results_taken;
	longint cycles;

	segment_box_blockage_loss_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	sbbl_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .pending(pending)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("segment_box_blockage_loss_unit verification failed");
		$finish;
	end

	initial results_taken = 0;
	always @(posedge clk)
		if (out_valid && out_ready)
			results_taken++;

	// result side: rotating stall pattern, one long hold-off
	initial begin
		int cyc;
		bit held;
		cyc = 0;
		held = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (!held && results_taken >= 150) begin
				out_ready = 1'b0;
				repeat (3000) @(negedge clk);
				held = 1;
			end
			case ((cyc / 97) % 4)
				0: out_ready = 1'b1;
				1: out_ready = $urandom_range(0, 1) == 1;
				2: out_ready = $urandom_range(0, 3) == 0;
				default: out_ready = (cyc % 7) != 0;
			endcase
		end
	end

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send(in_item_t it);
		in_data = it;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		if (burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = $urandom_range(0, 7) == 0 ? 200 : $urandom_range(1, 24);
		end else
			burst_left--;
	endtask

	task automatic wait_idle();
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	function automatic in_item_t query(int xa, int ya, int za, int xb, int yb, int zb);
		in_item_t it;
		it.operation = OP_QUERY;
		it.slot = SLOT_W'($urandom);
		it.loss_weight = WEIGHT_W'($urandom);
		it.x_a = COORD_W'(xa);
		it.y_a = COORD_W'(ya);
		it.z_a = COORD_W'(za);
		it.x_b = COORD_W'(xb);
		it.y_b = COORD_W'(yb);
		it.z_b = COORD_W'(zb);
		return it;
	endfunction

	function automatic in_item_t load(int s, int xl, int yl, int zl, int xh, int yh, int zh,
			int w);
		in_item_t it;
		it = query(xl, yl, zl, xh, yh, zh);
		it.operation = OP_LOAD;
		it.slot = SLOT_W'(s);
		it.loss_weight = WEIGHT_W'(w);
		return it;
	endfunction

	function automatic int near_coord();
		if ($urandom_range(0, 4) == 0)
			return int'($urandom) <<< 8 >>> 8;
		return int'($urandom_range(0, 8192)) - 4096;
	endfunction

	function automatic in_item_t random_box(int s);
		int lo[3], hi[3];
		int r;
		r = $urandom_range(0, 9);
		for (int k = 0; k < 3; k++) begin
			if (s % 8 == 0 || r == 0) begin
				lo[k] = -int'($urandom_range(1000000, 8388608));
				hi[k] = int'($urandom_range(1000000, 8388607));
			end else begin
				lo[k] = int'($urandom_range(0, 8192)) - 4096;
				hi[k] = lo[k] + int'($urandom_range(0, 3000));
			end
			if (r == 1)
				hi[k] = lo[k] - int'($urandom_range(1, 2000));
			if (r == 2)
				lo[k] = int'($urandom) <<< 8 >>> 8;
		end
		return load(s, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], $urandom_range(0, 4095));
	endfunction

	function automatic in_item_t random_query();
		return query(near_coord(), near_coord(), near_coord(),
			near_coord(), near_coord(), near_coord());
	endfunction

	initial begin
		int n_obs;
		int n_items;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		burst_left = 5;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every slot gets a box before any query reads it
		cfg_write(REG_OBSTACLE_COUNT, CFG_DATA_W'(0));
		cfg_write(REG_AP_SIZE_X, CFG_DATA_W'(0));
		cfg_write(REG_AP_SIZE_Y, CFG_DATA_W'(0));
		cfg_write(REG_AP_SIZE_Z, CFG_DATA_W'(0));
		for (int s = 0; s < MAX_OBSTACLES; s++)
			send(random_box(s));
		send(load(0, -8388608, -8388608, -8388608, 8388607, 8388607, 8388607, 4095));
		send(load(1, 2000, 2000, 2000, -2000, -2000, -2000, 777));
		send(load(2, -500, -500, -500, 500, 500, 500, 0));
		send(load(3, -1024, -1024, -1024, 1024, 1024, 1024, 4095));
		send(load(255, -100, -100, -100, 100, 100, 100, 4095));
		wait_idle();
		cfg_write(REG_OBSTACLE_COUNT, CFG_DATA_W'(4));

		send(query(-3000, 0, 0, 3000, 0, 0));
		send(query(-3000, 0, 0, 0, 0, 0));
		send(query(-3000, 0, 0, -1024, 0, 0));
		send(query(-3000, 1024, 0, 3000, 1024, 0));
		send(query(0, -3000, 0, 0, 3000, 0));
		send(query(0, 0, 3000, 0, 0, -3000));
		send(query(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608));
		send(query(8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
		send(query(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
		send(query(8388607, -8388608, 8388607, -8388608, 8388607, -8388608));
		wait_idle();
		cfg_write(REG_AP_SIZE_X, CFG_DATA_W'(10240));
		cfg_write(REG_AP_SIZE_Y, CFG_DATA_W'(10240));
		cfg_write(REG_AP_SIZE_Z, CFG_DATA_W'(10240));
		send(query(-3000, 0, 0, 3000, 0, 0));
		send(query(5120, 5120, 5120, 0, 0, 0));
		wait_idle();
		cfg_write(REG_OBSTACLE_COUNT, CFG_DATA_W'(0));
		cfg_write(REG_AP_SIZE_X, 16'hFFFF);
		cfg_write(REG_AP_SIZE_Y, 16'hFFFF);
		cfg_write(REG_AP_SIZE_Z, 16'hFFFF);
		cfg_write(8'hFF, 16'hFFFF);
		send(query(-3000, 0, 0, 3000, 0, 0));
		wait_idle();
		cfg_write(REG_OBSTACLE_COUNT, 16'hFFFF);
		send(query(-8000000, -8000000, -8000000, 8000000, 8000000, 8000000));
		send(query(0, 0, 0, 3000, -2000, 1000));
		wait_idle();
		cfg_write(REG_OBSTACLE_COUNT, CFG_DATA_W'(MAX_OBSTACLES));
		cfg_write(REG_AP_SIZE_X, CFG_DATA_W'(0));
		cfg_write(REG_AP_SIZE_Y, CFG_DATA_W'(0));
		cfg_write(REG_AP_SIZE_Z, CFG_DATA_W'(0));
		send(query(8388607, 8388607, 8388607, -8388608, -8388608, -8388608));
		wait_idle();

		for (int ph = 0; ph < 12; ph++) begin
			case ($urandom_range(0, 9))
				0: n_obs = 0;
				1: n_obs = $urandom_range(200, 511);
				default: n_obs = $urandom_range(1, 10);
			endcase
			cfg_write(REG_OBSTACLE_COUNT, CFG_DATA_W'(n_obs));
			cfg_write(REG_AP_SIZE_X, CFG_DATA_W'($urandom_range(0, 3) == 0 ? $urandom
				: $urandom_range(0, 10240)));
			cfg_write(REG_AP_SIZE_Y, CFG_DATA_W'($urandom_range(0, 3) == 0 ? $urandom
				: $urandom_range(0, 10240)));
			cfg_write(REG_AP_SIZE_Z, CFG_DATA_W'($urandom_range(0, 3) == 0 ? $urandom
				: $urandom_range(0, 10240)));
			cfg_write(CFG_IDX_W'($urandom_range(4, 255)), CFG_DATA_W'($urandom));
			n_items = n_obs > 16 ? 6 : 125;
			for (int i = 0; i < n_items; i++) begin
				if (ph == 5 && i == 60)
					wait_idle();
				if ($urandom_range(0, 4) == 0)
					send(random_box($urandom_range(0, 1) ? $urandom_range(0, n_obs > 255 ?
						255 : n_obs) : $urandom_range(0, 255)));
				else
					send(random_query());
			end
			wait_idle();
		end

		if (mismatches == 0 && pending == 0)
			$display("segment_box_blockage_loss_unit verification clean");
		else
			$display("segment_box_blockage_loss_unit verification failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/sbbl_pkg.sv
rtl/sbbl_ram.sv
rtl/sbbl_div.sv
rtl/sbbl_sqrt.sv
rtl/segment_box_blockage_loss_unit.sv
tb/sv/sbbl_checker.sv
tb/sv/segment_box_blockage_loss_unit_test.sv
